/* rtl/core/rfa_pkg.sv */
// Types, constants and lookup functions shared by the Rastrigin fitness accumulator.
`timescale 1ns / 1ps

package rfa_pkg;

    localparam int FRAC_BITS    = 12;

    localparam int COORD_W      = 16;
    localparam int SAMPLE_W     = 16;
    localparam int BIAS_W       = 23;
    localparam int FIT_W        = 29;
    localparam int SUM_W        = 29;
    localparam int CFG_INDEX_W  = 8;

    localparam int V_W          = COORD_W + 1;
    localparam int ABS_W        = COORD_W;
    localparam int MUL_B_W      = 18;
    localparam int PROD_W       = ABS_W + MUL_B_W;
    localparam int NOISE_W      = 7;
    localparam int SQ_W         = 2 * ABS_W + 1 - FRAC_BITS;
    localparam int PHASE_W      = 16;
    localparam int CORDIC_W     = 32;
    localparam int Z_W          = 33;
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = 4;
    localparam int TEN_W        = CORDIC_W + 4;
    localparam int TC_SHIFT     = 30 - FRAC_BITS;
    localparam int TC_W         = TEN_W - TC_SHIFT;
    localparam int TERM_W       = SQ_W + 2;
    localparam int NOISE_SHIFT  = 40 - FRAC_BITS;

    localparam logic [MUL_B_W-1:0]        NOISE_K     = MUL_B_W'(167772);
    localparam logic [PROD_W:0]           NOISE_RND   = (PROD_W + 1)'(1) << (39 - FRAC_BITS);
    localparam logic [PROD_W:0]           SQ_RND      = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
    localparam logic signed [TEN_W-1:0]   TEN_RND     = TEN_W'(1) << (29 - FRAC_BITS);
    localparam logic signed [TERM_W-1:0]  TEN_ONE     = TERM_W'(10) << FRAC_BITS;

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(268435455);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(268435456);
    localparam logic signed [SUM_W:0] FIT_MAX = (SUM_W + 1)'(213811200);
    localparam logic signed [SUM_W:0] FIT_MIN = -(SUM_W + 1)'(4096000);

    localparam logic [CFG_INDEX_W-1:0] CFG_NOISY_MODE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS       = CFG_INDEX_W'(1);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NOISE,
        S_SETUP,
        S_CORDIC,
        S_TERM,
        S_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        Q_COS_POS,
        Q_SIN_NEG,
        Q_COS_NEG,
        Q_SIN_POS
    } t_quad;

    function automatic logic signed [Z_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            4'd0:    a = Z_W'(536870912);
            4'd1:    a = Z_W'(316933406);
            4'd2:    a = Z_W'(167458907);
            4'd3:    a = Z_W'(85004756);
            4'd4:    a = Z_W'(42667331);
            4'd5:    a = Z_W'(21354465);
            4'd6:    a = Z_W'(10680862);
            4'd7:    a = Z_W'(5340245);
            4'd8:    a = Z_W'(2670163);
            4'd9:    a = Z_W'(1335087);
            4'd10:   a = Z_W'(667544);
            4'd11:   a = Z_W'(333772);
            4'd12:   a = Z_W'(166886);
            4'd13:   a = Z_W'(83443);
            4'd14:   a = Z_W'(41721);
            4'd15:   a = Z_W'(20861);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/core/rastrigin_fitness_accumulator_top.sv */
// Top level of the Rastrigin fitness accumulator: sequencer, shared multiplier and CORDIC.
`timescale 1ns / 1ps

// Channel   Direction  Signals
// in        sink       i_in_valid, o_in_ready, i_coordinate, i_uniform_sample, i_is_last
// out       source     o_out_valid, i_out_ready, o_fitness
// cfg       sink       i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// A beat on in occupies the block through noise, setup, 16 CORDIC steps, term and
// accumulate; a last beat adds an emit state that loads the result register.
// The CORDIC loop and the single shared multiplier hold off a new beat until the last is through.
// Reset clears the sum, the configuration registers, the output valid and all control state.
// A last beat waits in the emit state while an earlier result is still unread.
module rastrigin_fitness_accumulator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [rfa_pkg::COORD_W-1:0]   i_coordinate,
    input  logic        [rfa_pkg::SAMPLE_W-1:0]  i_uniform_sample,
    input  logic                                 i_is_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rfa_pkg::FIT_W-1:0]     o_fitness,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [rfa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic        [rfa_pkg::BIAS_W-1:0]    i_cfg_data
);

    rfa_pkg::t_state r_state, n_state;

    logic                                   r_noisy;
    logic signed [rfa_pkg::BIAS_W-1:0]      r_bias;
    logic signed [rfa_pkg::SUM_W-1:0]       r_sum;
    logic signed [rfa_pkg::COORD_W-1:0]     r_coord;
    logic        [rfa_pkg::SAMPLE_W-1:0]    r_sample;
    logic                                   r_last;
    logic        [rfa_pkg::NOISE_W-1:0]     r_noise;
    logic        [rfa_pkg::ABS_W-1:0]       r_abs;
    logic        [rfa_pkg::SQ_W-1:0]        r_sq;
    logic signed [rfa_pkg::CORDIC_W-1:0]    r_x;
    logic signed [rfa_pkg::CORDIC_W-1:0]    r_y;
    logic signed [rfa_pkg::Z_W-1:0]         r_z;
    rfa_pkg::t_quad                         r_quad;
    logic        [rfa_pkg::ITER_W-1:0]      r_iter;
    logic signed [rfa_pkg::TERM_W-1:0]      r_term;
    logic                                   r_out_valid;
    logic signed [rfa_pkg::FIT_W-1:0]       r_fit;

    logic                                   in_fire;
    logic                                   emit_fire;

    logic        [rfa_pkg::ABS_W-1:0]       mul_a;
    logic        [rfa_pkg::MUL_B_W-1:0]     mul_b;
    logic        [rfa_pkg::PROD_W-1:0]      prod;
    logic        [rfa_pkg::PROD_W:0]        noise_full;
    logic        [rfa_pkg::PROD_W:0]        sq_full;

    logic signed [rfa_pkg::V_W-1:0]         v_next;
    logic signed [rfa_pkg::V_W-1:0]         v_neg;
    logic        [rfa_pkg::FRAC_BITS-1:0]   phase;
    logic        [rfa_pkg::PHASE_W-1:0]     p16;

    logic signed [rfa_pkg::CORDIC_W-1:0]    dx;
    logic signed [rfa_pkg::CORDIC_W-1:0]    dy;
    logic signed [rfa_pkg::Z_W-1:0]         atan_i;

    logic signed [rfa_pkg::CORDIC_W-1:0]    cos_val;
    logic signed [rfa_pkg::TEN_W-1:0]       cos_ext;
    logic signed [rfa_pkg::TEN_W-1:0]       ten_cos;
    logic signed [rfa_pkg::TEN_W-1:0]       tc_full;
    logic signed [rfa_pkg::TC_W-1:0]        tc;
    logic signed [rfa_pkg::TERM_W-1:0]      term;

    logic signed [rfa_pkg::SUM_W:0]         acc;
    logic signed [rfa_pkg::SUM_W-1:0]       acc_sat;
    logic signed [rfa_pkg::SUM_W:0]         fit_raw;
    logic signed [rfa_pkg::FIT_W-1:0]       fit_sat;

    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_fitness   = r_fit;
    assign in_fire     = i_in_valid && o_in_ready;

    // shared multiplier: noise scaling, then the square
    assign mul_a      = (r_state == rfa_pkg::S_NOISE) ? r_sample : r_abs;
    assign mul_b      = (r_state == rfa_pkg::S_NOISE) ? rfa_pkg::NOISE_K
                                                      : rfa_pkg::MUL_B_W'(r_abs);
    assign prod       = rfa_pkg::PROD_W'(mul_a) * rfa_pkg::PROD_W'(mul_b);
    assign noise_full = {1'b0, prod} + rfa_pkg::NOISE_RND;
    assign sq_full    = {1'b0, prod} + rfa_pkg::SQ_RND;

    assign v_next = rfa_pkg::V_W'(r_coord)
                  + (r_noisy ? $signed(rfa_pkg::V_W'(r_noise)) : '0);
    assign v_neg  = -v_next;
    assign phase  = v_next[rfa_pkg::FRAC_BITS-1:0];
    assign p16    = rfa_pkg::PHASE_W'({phase, {rfa_pkg::PHASE_W{1'b0}}} >> rfa_pkg::FRAC_BITS);

    assign dx     = r_y >>> r_iter;
    assign dy     = r_x >>> r_iter;
    assign atan_i = rfa_pkg::atan_turn(r_iter);

    always_comb begin
        case (r_quad)
            rfa_pkg::Q_COS_POS: cos_val = r_x;
            rfa_pkg::Q_SIN_NEG: cos_val = -r_y;
            rfa_pkg::Q_COS_NEG: cos_val = -r_x;
            rfa_pkg::Q_SIN_POS: cos_val = r_y;
            default:            cos_val = r_x;
        endcase
    end

    assign cos_ext = rfa_pkg::TEN_W'(cos_val);
    assign ten_cos = (cos_ext <<< 3) + (cos_ext <<< 1);
    assign tc_full = ten_cos + rfa_pkg::TEN_RND;
    assign tc      = rfa_pkg::TC_W'(tc_full >>> rfa_pkg::TC_SHIFT);
    assign term    = $signed({2'b00, r_sq}) - rfa_pkg::TERM_W'(tc) + rfa_pkg::TEN_ONE;

    assign acc = rfa_pkg::SUM_W'(0) + (rfa_pkg::SUM_W + 1)'(r_sum)
               + (rfa_pkg::SUM_W + 1)'(r_term);

    always_comb begin
        if (acc > rfa_pkg::SUM_MAX) begin
            acc_sat = rfa_pkg::SUM_W'(rfa_pkg::SUM_MAX);
        end else if (acc < rfa_pkg::SUM_MIN) begin
            acc_sat = rfa_pkg::SUM_W'(rfa_pkg::SUM_MIN);
        end else begin
            acc_sat = rfa_pkg::SUM_W'(acc);
        end
    end

    assign fit_raw = (rfa_pkg::SUM_W + 1)'(r_sum) + (rfa_pkg::SUM_W + 1)'(r_bias);

    always_comb begin
        if (fit_raw > rfa_pkg::FIT_MAX) begin
            fit_sat = rfa_pkg::FIT_W'(rfa_pkg::FIT_MAX);
        end else if (fit_raw < rfa_pkg::FIT_MIN) begin
            fit_sat = rfa_pkg::FIT_W'(rfa_pkg::FIT_MIN);
        end else begin
            fit_sat = rfa_pkg::FIT_W'(fit_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        emit_fire  = 1'b0;
        case (r_state)
            rfa_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_state = rfa_pkg::S_NOISE;
                end
            end
            rfa_pkg::S_NOISE: begin
                n_state = rfa_pkg::S_SETUP;
            end
            rfa_pkg::S_SETUP: begin
                n_state = rfa_pkg::S_CORDIC;
            end
            rfa_pkg::S_CORDIC: begin
                if (r_iter == rfa_pkg::ITER_LAST) begin
                    n_state = rfa_pkg::S_TERM;
                end
            end
            rfa_pkg::S_TERM: begin
                n_state = rfa_pkg::S_ACC;
            end
            rfa_pkg::S_ACC: begin
                n_state = r_last ? rfa_pkg::S_EMIT : rfa_pkg::S_IDLE;
            end
            rfa_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    emit_fire = 1'b1;
                    n_state   = rfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noisy     <= 1'b0;
            r_bias      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rfa_pkg::CFG_NOISY_MODE: r_noisy <= i_cfg_data[0];
                    rfa_pkg::CFG_BIAS:       r_bias  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == rfa_pkg::S_SETUP) begin
                r_iter <= '0;
            end else if (r_state == rfa_pkg::S_CORDIC) begin
                r_iter <= r_iter + 1'b1;
            end
            if (r_state == rfa_pkg::S_ACC) begin
                r_sum <= acc_sat;
            end else if (emit_fire) begin
                r_sum <= '0;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_coord  <= i_coordinate;
            r_sample <= i_uniform_sample;
            r_last   <= i_is_last;
        end
        if (r_state == rfa_pkg::S_NOISE) begin
            r_noise <= noise_full[rfa_pkg::NOISE_SHIFT +: rfa_pkg::NOISE_W];
        end
        if (r_state == rfa_pkg::S_SETUP) begin
            r_abs  <= v_next[rfa_pkg::V_W-1] ? rfa_pkg::ABS_W'(v_neg)
                                             : rfa_pkg::ABS_W'(v_next);
            r_x    <= rfa_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= rfa_pkg::Z_W'({p16[rfa_pkg::PHASE_W-3:0], {rfa_pkg::PHASE_W{1'b0}}});
            r_quad <= rfa_pkg::t_quad'(p16[rfa_pkg::PHASE_W-1 -: 2]);
        end
        if (r_state == rfa_pkg::S_CORDIC) begin
            if (r_iter == '0) begin
                r_sq <= sq_full[rfa_pkg::FRAC_BITS +: rfa_pkg::SQ_W];
            end
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_i;
            end
        end
        if (r_state == rfa_pkg::S_TERM) begin
            r_term <= term;
        end
        if (emit_fire) begin
            r_fit <= fit_sat;
        end
    end

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_cordic_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfa_pkg::S_CORDIC) && (r_iter == rfa_pkg::ITER_LAST)
        |=> (r_state == rfa_pkg::S_TERM))
        else $error("CORDIC loop did not end after its last step");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |=> (r_sum == '0) && r_out_valid)
        else $error("sum not cleared or result not shown after last beat");

    a_fit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((rfa_pkg::SUM_W + 1)'(r_fit) <= rfa_pkg::FIT_MAX)
                     && ((rfa_pkg::SUM_W + 1)'(r_fit) >= rfa_pkg::FIT_MIN))
        else $error("fitness outside its clamp range");

endmodule
